// ===== hw/rtl/urrs_pkg.sv =====
package urrs_pkg;

    // Data word width of the random source and bounds
    localparam int unsigned WORD_W = 32;

    // Divider step counter width, indexes WORD_W steps
    localparam int unsigned CNT_W = $clog2(WORD_W);

    // Opcodes
    localparam logic OP_UNBIASED = 1'b0;
    localparam logic OP_BIASED   = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } urrs_state_t;

endpackage

// ===== hw/rtl/unbiased_range_rejection_sampler_top.sv =====
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    opcode, random_word, range_low, range_high
// out       source     out_valid / out_stall  sample_value, accepted
// cfg       sink       cfg_valid / cfg_ready  cfg_data (no_repeat_enable)
//
// A transaction runs from acceptance to a loaded result in order: a capture step,
// WORD_W steps of the shared restoring divider, then the finish state.
// The divider step reduces the random word and (2^WORD_W - span) by the span side by side.
// The result sits in an output register; a stalled result holds the block in its
// finish cycle only when a second result is ready behind it.
// rst_n clears the sequencer, the output valid, the repeat-guard state and the config register.
module unbiased_range_rejection_sampler_top
    import urrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [WORD_W-1:0] random_word,
    input  logic [WORD_W-1:0] range_low,
    input  logic [WORD_W-1:0] range_high,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] sample_value,
    output logic              accepted,
    // configuration channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    urrs_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              op_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] low_reg;
    logic [WORD_W-1:0] span_reg;
    logic [WORD_W-1:0] dvd_a_reg, dvd_a_next;
    logic [WORD_W-1:0] dvd_b_reg, dvd_b_next;
    logic [WORD_W-1:0] rem_a_reg, rem_a_next;
    logic [WORD_W-1:0] rem_b_reg, rem_b_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] sample_value_reg;
    logic              accepted_reg;

    logic              no_repeat_reg;
    logic [WORD_W-1:0] prev_value_reg;
    logic              prev_valid_reg;

    logic              load_in;
    logic              div_step;
    logic              load_out;
    logic              out_free;

    logic [WORD_W-1:0] span_in;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample_value = sample_value_reg;
    assign accepted = accepted_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign span_in = range_high - range_low + WORD_W'(1);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall = 1'b1;
        load_in  = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                load_in  = in_valid;
            end
            ST_DIVIDE:
            begin
                div_step = 1'b1;
            end
            ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Shared divider step: reduce both dividends by the span, one bit each
    // ------------------------------------------------------------------
    logic [WORD_W:0] trial_a, trial_b;
    logic [WORD_W:0] diff_a, diff_b;

    always_comb
    begin
        trial_a = {rem_a_reg, dvd_a_reg[WORD_W-1]};
        trial_b = {rem_b_reg, dvd_b_reg[WORD_W-1]};
        diff_a  = trial_a - {1'b0, span_reg};
        diff_b  = trial_b - {1'b0, span_reg};

        cnt_next   = cnt_reg;
        dvd_a_next = dvd_a_reg;
        dvd_b_next = dvd_b_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;

        if (load_in)
        begin
            cnt_next   = CNT_W'(WORD_W - 1);
            dvd_a_next = random_word;
            dvd_b_next = '0 - span_in;
            rem_a_next = '0;
            rem_b_next = '0;
        end
        else if (div_step)
        begin
            cnt_next   = cnt_reg - CNT_W'(1);
            dvd_a_next = {dvd_a_reg[WORD_W-2:0], 1'b0};
            dvd_b_next = {dvd_b_reg[WORD_W-2:0], 1'b0};
            rem_a_next = diff_a[WORD_W] ? trial_a[WORD_W-1:0] : diff_a[WORD_W-1:0];
            rem_b_next = diff_b[WORD_W] ? trial_b[WORD_W-1:0] : diff_b[WORD_W-1:0];
        end
    end

    // Hold the item fields and the divider registers
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            op_reg   <= opcode;
            word_reg <= random_word;
            low_reg  <= range_low;
            span_reg <= span_in;
        end
        cnt_reg   <= cnt_next;
        dvd_a_reg <= dvd_a_next;
        dvd_b_reg <= dvd_b_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
    end

    // ------------------------------------------------------------------
    // Finish: shift by the lower bound; in unbiased mode apply size and repeat rejection
    // ------------------------------------------------------------------
    logic              span_zero;
    logic [WORD_W-1:0] word_mod;
    logic [WORD_W-1:0] tail_mod;
    logic [WORD_W-1:0] value;
    logic [WORD_W:0]   size_sum;
    logic              size_reject;
    logic              repeat_reject;
    logic              reject;

    always_comb
    begin
        // A zero span stands for the full word range: no reduction, no size check
        span_zero     = (span_reg == '0);
        word_mod      = span_zero ? word_reg : rem_a_reg;
        tail_mod      = span_zero ? '0 : rem_b_reg;
        value         = word_mod + low_reg;
        // word >= 2^W - (2^W mod span) exactly when word + tail carries out
        size_sum      = {1'b0, word_reg} + {1'b0, tail_mod};
        size_reject   = size_sum[WORD_W];
        repeat_reject = no_repeat_reg && prev_valid_reg && (prev_value_reg == value);
        reject        = (op_reg == OP_UNBIASED) && (size_reject || repeat_reject);
    end

    // Output valid and the repeat-guard state
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_value_reg <= '0;
            no_repeat_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                no_repeat_reg <= cfg_data;
            end
            if (load_out && (op_reg == OP_UNBIASED) && !reject)
            begin
                prev_valid_reg <= 1'b1;
                prev_value_reg <= value;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sample_value_reg <= reject ? '0 : value;
            accepted_reg     <= !reject;
        end
    end

`ifndef NO_ASSERTIONS
    // An accepted input starts the divider
    a_start_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DIVIDE))
        else $error("accepted input did not start the divider");

    // The last divider step hands over to the finish cycle
    a_divide_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && cnt_reg == '0) |=> (state_reg == ST_FINISH))
        else $error("divider did not finish after its last step");

    // A rejected result carries a zero value
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (sample_value == '0))
        else $error("rejected result with nonzero value");

    // A result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !load_out)
        else $error("stalled result overwritten");
`endif

endmodule
